>>> hdl/pirs_pkg.sv
package pirs_pkg;

	localparam int ENTRIES_DEF = 512;

	localparam logic [15:0] ID_BASE   = 16'h9000;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// item modes; the unused code is treated as a read
	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_ALL   = 2'd2;

	typedef struct packed {
		logic [31:0] cnt;
		logic [31:0] tot;
		logic [31:0] last;
		logic [31:0] mn;
		logic [31:0] mx;
		logic [31:0] avg;
	} entry_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FETCH,
		S_DIV,
		S_WRITE,
		S_SWEEP
	} state_t;

	typedef enum logic [1:0] {
		OUT_ZERO,
		OUT_READ,
		OUT_NEW
	} out_sel_t;

endpackage

>>> hdl/per_id_runtime_statistics.sv
// Per-identifier runtime statistics. Items are taken when start is high and busy is low;
// every item gives exactly one result, shown for a single cycle with done high, and the
// receiver cannot hold it off. The table lives in one synchronous memory, ENTRIES deep,
// one word per identifier holding count, total, last, minimum, maximum and average.
// After reset the block clears the memory one entry a cycle, with busy high, before it
// takes its first item. An out-of-range record or read and an in-range clear are handled
// in the idle state, so a new item may follow at once. A read fetches the entry and then
// returns to idle. A record goes through one memory read, 32 steps of the bit-serial
// divider that forms the average, and the write-back, before the next item is taken.
// A clear with an identifier outside the window clears the whole table, and its result
// comes after the last entry is written.
module per_id_runtime_statistics
	import pirs_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] msg_id,
	input  logic [31:0] duration,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] call_count,
	output logic [31:0] total_time,
	output logic [31:0] last_time,
	output logic [31:0] min_time,
	output logic [31:0] max_time,
	output logic [31:0] avg_time
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0] sweep_q;
	logic             sweep_last;

	logic [15:0]      id_off;
	logic             in_range;
	logic [IDX_W-1:0] in_idx;

	logic [1:0]       mode_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      delta_q;

	entry_t           mem [ENTRIES];
	entry_t           rd_data_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_ra;
	entry_t           mem_wd;

	entry_t           ent_q;
	entry_t           base;
	entry_t           upd;
	entry_t           wr_ent;
	logic [32:0]      sum;
	logic             wrap;

	logic [31:0]      div_rem_q;
	logic [31:0]      div_quo_q;
	logic [4:0]       div_cnt_q;
	logic [32:0]      div_sh;
	logic [32:0]      div_diff;

	logic             out_load;
	logic [1:0]       out_status;
	out_sel_t         out_sel;
	logic             done_q;
	logic [1:0]       status_q;
	entry_t           res_q;

	// identifier window check
	assign id_off   = msg_id - ID_BASE;
	assign in_range = (msg_id >= ID_BASE) && (id_off < 16'(ENTRIES));
	assign in_idx   = id_off[IDX_W-1:0];

	assign sweep_last = (sweep_q == IDX_LAST);

	// record update from the fetched entry
	always_comb begin
		sum  = {1'b0, rd_data_q.tot} + {1'b0, delta_q};
		wrap = (rd_data_q.cnt == COUNT_MAX) || sum[32];
		base = wrap ? entry_t'('0) : rd_data_q;
		upd.cnt  = base.cnt + 32'd1;
		upd.tot  = base.tot + delta_q;
		upd.last = delta_q;
		upd.mn   = ((base.cnt == '0) || (delta_q < base.mn)) ? delta_q : base.mn;
		upd.mx   = (delta_q > base.mx) ? delta_q : base.mx;
		upd.avg  = '0;
	end

	// restoring divider step, total over count
	assign div_sh   = {div_rem_q, div_quo_q[31]};
	assign div_diff = div_sh - {1'b0, ent_q.cnt};

	always_comb begin
		wr_ent     = ent_q;
		wr_ent.avg = div_quo_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (mode)
						MODE_RECORD: if (in_range) state_d = S_FETCH;
						MODE_CLEAR:  if (!in_range) state_d = S_SWEEP;
						default:     if (in_range) state_d = S_FETCH;
					endcase
				end
			end
			S_FETCH: begin
				state_d = (mode_q == MODE_RECORD) ? S_DIV : S_IDLE;
			end
			S_DIV: begin
				if (div_cnt_q == 5'd31) state_d = S_WRITE;
			end
			S_WRITE: begin
				state_d = S_IDLE;
			end
			S_SWEEP: begin
				if (sweep_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy       = 1'b1;
		mem_we     = 1'b0;
		mem_wa     = idx_q;
		mem_wd     = '0;
		mem_ra     = idx_q;
		out_load   = 1'b0;
		out_status = ST_DONE;
		out_sel    = OUT_ZERO;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
			end
			S_IDLE: begin
				busy   = 1'b0;
				mem_ra = in_idx;
				if (start) begin
					case (mode)
						MODE_RECORD: begin
							if (!in_range) begin
								out_load   = 1'b1;
								out_status = ST_RANGE;
							end
						end
						MODE_CLEAR: begin
							if (in_range) begin
								mem_we   = 1'b1;
								mem_wa   = in_idx;
								out_load = 1'b1;
							end
						end
						default: begin
							if (!in_range) begin
								out_load   = 1'b1;
								out_status = ST_RANGE;
							end
						end
					endcase
				end
			end
			S_FETCH: begin
				if (mode_q != MODE_RECORD) begin
					out_load = 1'b1;
					out_sel  = OUT_READ;
				end
			end
			S_DIV: begin
			end
			S_WRITE: begin
				mem_we   = 1'b1;
				mem_wd   = wr_ent;
				out_load = 1'b1;
				out_sel  = OUT_NEW;
			end
			S_SWEEP: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
				if (sweep_last) begin
					out_load   = 1'b1;
					out_status = ST_ALL;
				end
			end
			default: begin
			end
		endcase
	end

	// statistics memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[mem_ra];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_load;
			if (state_q == S_INIT || state_q == S_SWEEP) begin
				sweep_q <= sweep_last ? '0 : sweep_q + IDX_W'(1);
			end
		end
	end

	// item, update and divider
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q  <= mode;
			idx_q   <= in_idx;
			delta_q <= duration;
		end
		if (state_q == S_FETCH) begin
			ent_q     <= upd;
			div_rem_q <= '0;
			div_quo_q <= upd.tot;
			div_cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			div_rem_q <= div_diff[32] ? div_sh[31:0] : div_diff[31:0];
			div_quo_q <= {div_quo_q[30:0], ~div_diff[32]};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
		if (out_load) begin
			status_q <= out_status;
			case (out_sel)
				OUT_READ: res_q <= rd_data_q;
				OUT_NEW:  res_q <= wr_ent;
				default:  res_q <= '0;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign call_count = res_q.cnt;
	assign total_time = res_q.tot;
	assign last_time  = res_q.last;
	assign min_time   = res_q.mn;
	assign max_time   = res_q.mx;
	assign avg_time   = res_q.avg;

	// a result always leaves the block ready for the next item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// the divisor is never zero
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (ent_q.cnt != '0))
		else $error("division by zero count");

	// a live entry keeps min <= avg <= max
	a_stats_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DONE && call_count != '0) |->
		(min_time <= avg_time && avg_time <= max_time && avg_time <= total_time))
		else $error("inconsistent statistics");

	// clearing the whole table reports an empty entry
	a_clear_all_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_ALL) |-> (call_count == '0 && total_time == '0))
		else $error("clear-all result not zero");

endmodule

>>> dv/per_id_runtime_statistics_tb.sv
module per_id_runtime_statistics_tb;
	import pirs_pkg::*;

	localparam int TABLE_DEPTH = ENTRIES_DEF;
	localparam int MAX_GAP = 17;
	localparam int RANDOM_ITEMS = 500;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1_200_000;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] id;
		logic [31:0] delta;
		int          gap;
	} stats_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] cnt;
		logic [31:0] tot;
		logic [31:0] last;
		logic [31:0] mn;
		logic [31:0] mx;
		logic [31:0] avg;
	} stats_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_RECORD;
	logic [15:0] msg_id = '0;
	logic [31:0] duration = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [31:0] call_count;
	logic [31:0] total_time;
	logic [31:0] last_time;
	logic [31:0] min_time;
	logic [31:0] max_time;
	logic [31:0] avg_time;

	logic [31:0] cnt_tab  [TABLE_DEPTH];
	logic [31:0] tot_tab  [TABLE_DEPTH];
	logic [31:0] last_tab [TABLE_DEPTH];
	logic [31:0] min_tab  [TABLE_DEPTH];
	logic [31:0] max_tab  [TABLE_DEPTH];
	logic [31:0] avg_tab  [TABLE_DEPTH];

	stats_cmd_t  pending_q[$];
	stats_view_t expected_q[$];
	stats_cmd_t  next_cmd;
	stats_view_t oldest;
	int          idle_cycles = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;

	per_id_runtime_statistics uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.msg_id     (msg_id),
		.duration   (duration),
		.done       (done),
		.status     (status),
		.call_count (call_count),
		.total_time (total_time),
		.last_time  (last_time),
		.min_time   (min_time),
		.max_time   (max_time),
		.avg_time   (avg_time)
	);

	always #5 clk = ~clk;

	function automatic void wipe_entry(int idx);
		cnt_tab[idx]  = '0;
		tot_tab[idx]  = '0;
		last_tab[idx] = '0;
		min_tab[idx]  = '0;
		max_tab[idx]  = '0;
		avg_tab[idx]  = '0;
	endfunction

	function automatic stats_view_t entry_view(int idx);
		stats_view_t v;
		v.status = ST_DONE;
		v.cnt    = cnt_tab[idx];
		v.tot    = tot_tab[idx];
		v.last   = last_tab[idx];
		v.mn     = min_tab[idx];
		v.mx     = max_tab[idx];
		v.avg    = avg_tab[idx];
		return v;
	endfunction

	function automatic stats_view_t update_stats(logic [1:0] m, logic [15:0] id,
			logic [31:0] d);
		stats_view_t r;
		int          idx;
		bit          in_win;
		logic [32:0] sum;
		r = '0;
		idx = int'(id) - int'(ID_BASE);
		in_win = (idx >= 0) && (idx < TABLE_DEPTH);
		if (m == MODE_RECORD) begin
			if (!in_win) begin
				r.status = ST_RANGE;
			end else begin
				sum = {1'b0, tot_tab[idx]} + {1'b0, d};
				// saturated count or wrapping total restarts the entry
				if (cnt_tab[idx] == COUNT_MAX || sum[32])
					wipe_entry(idx);
				cnt_tab[idx]  = cnt_tab[idx] + 32'd1;
				last_tab[idx] = d;
				tot_tab[idx]  = tot_tab[idx] + d;
				if (cnt_tab[idx] == 32'd1 || d < min_tab[idx])
					min_tab[idx] = d;
				if (d > max_tab[idx])
					max_tab[idx] = d;
				avg_tab[idx] = tot_tab[idx] / cnt_tab[idx];
				r = entry_view(idx);
			end
		end else if (m == MODE_CLEAR) begin
			if (in_win) begin
				wipe_entry(idx);
				r.status = ST_DONE;
			end else begin
				for (int k = 0; k < TABLE_DEPTH; k++)
					wipe_entry(k);
				r.status = ST_ALL;
			end
		end else begin
			// unused mode decodes as a read
			if (in_win)
				r = entry_view(idx);
			else
				r.status = ST_RANGE;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic queue_cmd(logic [1:0] m, logic [15:0] id, logic [31:0] d);
		stats_cmd_t c;
		c.mode  = m;
		c.id    = id;
		c.delta = d;
		c.gap   = calm ? 0 : $urandom_range(0, MAX_GAP);
		pending_q.push_back(c);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (start && !busy)
				expected_q.push_back(update_stats(mode, msg_id, duration));
			if (!start || !busy) begin
				if (pending_q.size() == 0) begin
					start <= 1'b0;
				end else if (idle_cycles < pending_q[0].gap) begin
					start <= 1'b0;
					idle_cycles <= idle_cycles + 1;
				end else begin
					next_cmd = pending_q.pop_front();
					start <= 1'b1;
					mode <= next_cmd.mode;
					msg_id <= next_cmd.id;
					duration <= next_cmd.delta;
					idle_cycles <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding: status %h", status);
				fail_count++;
			end else begin
				oldest = expected_q.pop_front();
				check_field("status", 32'(oldest.status), 32'(status));
				check_field("call_count", oldest.cnt, call_count);
				check_field("total_time", oldest.tot, total_time);
				check_field("last_time", oldest.last, last_time);
				check_field("min_time", oldest.mn, min_time);
				check_field("max_time", oldest.mx, max_time);
				check_field("avg_time", oldest.avg, avg_time);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [15:0] hot_ids [6];
		logic [15:0] id;
		logic [31:0] d;
		logic [1:0]  m;
		int          pick;
		hot_ids = '{16'h9000, 16'h9001, 16'h9002, 16'h9100, 16'h91FE, 16'h91FF};
		for (int k = 0; k < TABLE_DEPTH; k++)
			wipe_entry(k);

		queue_cmd(MODE_RECORD, 16'h9000, 32'h0000_0000);
		queue_cmd(MODE_RECORD, 16'h9000, 32'hFFFF_FFFF);
		queue_cmd(MODE_RECORD, 16'h9000, 32'h0000_0001);
		queue_cmd(MODE_RECORD, 16'h9000, 32'h0000_0005);
		queue_cmd(MODE_RECORD, 16'h91FF, 32'hFFFF_FFFF);
		queue_cmd(MODE_RECORD, 16'h91FF, 32'hFFFF_FFFF);
		queue_cmd(MODE_READ,   16'h91FF, $urandom);
		queue_cmd(MODE_RECORD, 16'h8FFF, 32'h0000_0007);
		queue_cmd(MODE_RECORD, 16'h9200, 32'h0000_0007);
		queue_cmd(MODE_READ,   16'h9200, $urandom);
		queue_cmd(MODE_READ,   16'h0000, 32'h0000_0000);
		queue_cmd(MODE_RECORD, 16'hFFFF, 32'hAAAA_AAAA);
		queue_cmd(2'd3,        16'h9000, 32'hFFFF_FFFF);
		queue_cmd(MODE_CLEAR,  16'h9000, $urandom);
		queue_cmd(MODE_READ,   16'h9000, $urandom);
		queue_cmd(MODE_RECORD, 16'h9001, 32'h5555_5555);
		queue_cmd(MODE_RECORD, 16'h9001, 32'h1234_5678);
		queue_cmd(MODE_RECORD, 16'h9001, 32'h7FFF_FFFF);
		queue_cmd(MODE_CLEAR,  16'h8FFF, $urandom);
		queue_cmd(MODE_READ,   16'h9001, $urandom);
		queue_cmd(MODE_READ,   16'h91FF, $urandom);
		queue_cmd(2'd3,        16'hFFFF, $urandom);
		queue_cmd(MODE_CLEAR,  16'h91FF, $urandom);
		queue_cmd(MODE_RECORD, 16'h9100, 32'h0000_0003);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				calm = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				id = hot_ids[$urandom_range(0, 5)];
			else if (pick < 90)
				id = ID_BASE + 16'($urandom_range(0, TABLE_DEPTH - 1));
			else
				id = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				d = $urandom_range(0, 1000);
			else if (pick < 70)
				d = {2'b11, 30'($urandom)};
			else
				d = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				m = MODE_RECORD;
			else if (pick < 85)
				m = MODE_READ;
			else if (pick < 90)
				m = 2'd3;
			else
				m = MODE_CLEAR;
			queue_cmd(m, id, d);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start || expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
hdl/pirs_pkg.sv
hdl/per_id_runtime_statistics.sv
dv/per_id_runtime_statistics_tb.sv
